### sv/kv_cache_block_allocator_macros.svh
// Assertion macros for the paged block allocator.
// Used by the top level; needs clk and rst_n in scope where expanded.
`ifndef KV_CACHE_BLOCK_ALLOCATOR_MACROS_SVH
`define KV_CACHE_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define KVBA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("allocator invariant violated");
`define KVBA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator implication violated");
`else
`define KVBA_ASSERT_ALWAYS(lbl, expr)
`define KVBA_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

### sv/kvba_pkg.sv
// Shared constants and codes for the paged block allocator.
// No dependencies.
package kvba_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int NUM_SLOTS  = 16;
    localparam int MAX_BPS    = 64;

    localparam int BID_W  = 8;
    localparam int FC_W   = 9;
    localparam int SLOT_W = 4;
    localparam int LB_W   = 6;
    localparam int CNT_W  = 7;
    localparam int TOK_W  = 14;
    localparam int BS_W   = 9;
    localparam int DIVD_W = 15;
    localparam int TBL_AW = SLOT_W + LB_W;

    localparam logic [1:0] FUNC_GROW      = 2'd0;
    localparam logic [1:0] FUNC_RELEASE   = 2'd1;
    localparam logic [1:0] FUNC_TRANSLATE = 2'd2;
    localparam logic [1:0] FUNC_QUERY     = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;

    localparam logic [BS_W-1:0] BSIZE_RESET = 9'd16;

    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [BS_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIVD_W-1:0]   quotient;
    } div_rsp_t;

endpackage

### sv/kvba_if.sv
// Request and response channel interfaces of the block allocator.
// Depends on kvba_pkg for field widths.
interface kvba_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [kvba_pkg::SLOT_W-1:0]   request_slot;
    logic [kvba_pkg::TOK_W-1:0]    tokens;
    logic [kvba_pkg::LB_W-1:0]     lblock;

    modport source (output valid, func, request_slot, tokens, lblock,
                    input ready);
    modport sink (input valid, func, request_slot, tokens, lblock,
                  output ready);
endinterface

interface kvba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [kvba_pkg::BID_W-1:0]    physical_block;
    logic                          present;
    logic [kvba_pkg::CNT_W-1:0]    request_block_count;
    logic [kvba_pkg::FC_W-1:0]     free_block_count;

    modport source (output valid, status, physical_block, present,
                    request_block_count, free_block_count, input ready);
    modport sink (input valid, status, physical_block, present,
                  request_block_count, free_block_count, output ready);
endinterface

### sv/kvba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module kvba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/kvba_div.sv
// Restoring divider, one quotient bit per cycle, for the blocks-needed count.
// Depends on kvba_pkg.
module kvba_div (
    input  logic                clk,
    input  logic                rst_n,
    input  kvba_pkg::div_req_t  req,
    output kvba_pkg::div_rsp_t  rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [3:0]                  step_reg;
    logic [kvba_pkg::BS_W-1:0]   rem_reg;
    logic [kvba_pkg::BS_W-1:0]   dvs_reg;
    logic [kvba_pkg::DIVD_W-1:0] quo_reg;
    logic [kvba_pkg::BS_W:0]     trial;
    logic                        take;

    assign trial = {rem_reg, quo_reg[kvba_pkg::DIVD_W-1]};
    assign take  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(kvba_pkg::DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= (req.divisor == '0) ? kvba_pkg::BS_W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? kvba_pkg::BS_W'(trial - {1'b0, dvs_reg})
                            : trial[kvba_pkg::BS_W-1:0];
            quo_reg <= {quo_reg[kvba_pkg::DIVD_W-2:0], take};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/kvba_free_stack.sv
// Free stack of physical block ids: a RAM plus one valid bit per entry.
// An entry never written reads as its reset id. Depends on kvba_pkg, kvba_ram.
module kvba_free_stack (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [kvba_pkg::BID_W-1:0] waddr,
    input  logic [kvba_pkg::BID_W-1:0] wdata,
    input  logic [kvba_pkg::BID_W-1:0] raddr,
    output logic [kvba_pkg::BID_W-1:0] rdata
);

    logic [kvba_pkg::POOL_DEPTH-1:0] vld_reg;
    logic                            vld_q_reg;
    logic [kvba_pkg::BID_W-1:0]      raddr_q_reg;
    logic [kvba_pkg::BID_W-1:0]      ram_rdata;

    kvba_ram #(
        .WIDTH (kvba_pkg::BID_W),
        .DEPTH (kvba_pkg::POOL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_q_reg <= raddr;
    end

    assign rdata = vld_q_reg ? ram_rdata
                             : kvba_pkg::BID_W'(kvba_pkg::POOL_DEPTH - 1) - raddr_q_reg;

endmodule

### sv/kv_cache_block_allocator.sv
// Top level of the paged block allocator: sequencer, slot registers, RAMs.
// Depends on kvba_pkg, kvba_if, kvba_ram, kvba_div, kvba_free_stack.
//
//  Channel  Dir  Beat contents
//  req      in   func, request_slot, tokens, lblock
//  rsp      out  status, physical_block, present, request_block_count,
//                free_block_count
//  cfg      in   block-size write (cfg_we, cfg_wdata)
//
// One beat at a time. A grow first runs the divider (15 steps); a grow that takes
// blocks and a release of a present slot then move block ids through the RAMs,
// one id per cycle.
// The free stack is valid right after reset: no clearing pass.
// A finished result waits in the output register while the next beat is taken.
module kv_cache_block_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    kvba_req_if.sink                  req,
    kvba_rsp_if.source                rsp,
    input  logic                      cfg_we,
    input  logic [kvba_pkg::BS_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_GROW  = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;
    localparam logic [2:0] S_TWAIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                    state_reg;
    logic [kvba_pkg::BS_W-1:0]     bsize_reg;
    logic [kvba_pkg::FC_W-1:0]     free_count_reg;
    logic [kvba_pkg::CNT_W-1:0]    slot_cnt_reg [kvba_pkg::NUM_SLOTS];
    logic [kvba_pkg::NUM_SLOTS-1:0] slot_pres_reg;
    logic [1:0]                    func_reg;
    logic [kvba_pkg::SLOT_W-1:0]   slot_reg;
    logic [kvba_pkg::LB_W-1:0]     lb_reg;
    logic [kvba_pkg::DIVD_W-1:0]   quot_reg;
    logic [2:0]                    status_reg;
    logic [kvba_pkg::BID_W-1:0]    phys_reg;
    logic [kvba_pkg::CNT_W-1:0]    left_reg;
    logic [kvba_pkg::LB_W-1:0]     pos_reg;
    logic                          pend_reg;
    logic [kvba_pkg::TBL_AW-1:0]   wa_reg;

    logic                          out_valid_reg;
    logic [2:0]                    out_status_reg;
    logic [kvba_pkg::BID_W-1:0]    out_phys_reg;
    logic                          out_pres_reg;
    logic [kvba_pkg::CNT_W-1:0]    out_cnt_reg;
    logic [kvba_pkg::FC_W-1:0]     out_free_reg;

    logic                          accept;
    logic                          out_load;
    logic [kvba_pkg::CNT_W-1:0]    have;
    logic [kvba_pkg::CNT_W-1:0]    add;
    kvba_pkg::div_req_t            div_req;
    kvba_pkg::div_rsp_t            div_rsp;

    logic                          tbl_we;
    logic [kvba_pkg::TBL_AW-1:0]   tbl_raddr;
    logic [kvba_pkg::BID_W-1:0]    tbl_rdata;
    logic                          stk_we;
    logic [kvba_pkg::BID_W-1:0]    stk_rdata;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign have     = slot_cnt_reg[slot_reg];
    assign add      = kvba_pkg::CNT_W'(quot_reg) - have;

    assign div_req.start    = accept && (req.func == kvba_pkg::FUNC_GROW);
    assign div_req.dividend = kvba_pkg::DIVD_W'(req.tokens)
                              + kvba_pkg::DIVD_W'(bsize_reg)
                              - kvba_pkg::DIVD_W'(bsize_reg != '0);
    assign div_req.divisor  = bsize_reg;

    kvba_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign tbl_we    = pend_reg && (state_reg == S_GROW);
    assign tbl_raddr = (state_reg == S_EXEC) ? {slot_reg, lb_reg} : {slot_reg, pos_reg};

    kvba_ram #(
        .WIDTH (kvba_pkg::BID_W),
        .DEPTH (kvba_pkg::NUM_SLOTS * kvba_pkg::MAX_BPS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wa_reg),
        .wdata (stk_rdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign stk_we = pend_reg && (state_reg == S_REL)
                    && (free_count_reg != kvba_pkg::FC_W'(kvba_pkg::POOL_DEPTH));

    kvba_free_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (stk_we),
        .waddr (free_count_reg[kvba_pkg::BID_W-1:0]),
        .wdata (tbl_rdata),
        .raddr (kvba_pkg::BID_W'(free_count_reg - kvba_pkg::FC_W'(1))),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bsize_reg      <= kvba_pkg::BSIZE_RESET;
            free_count_reg <= kvba_pkg::FC_W'(kvba_pkg::POOL_DEPTH);
            slot_pres_reg  <= '0;
            pend_reg       <= 1'b0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < kvba_pkg::NUM_SLOTS; i++)
            begin
                slot_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                bsize_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (req.func == kvba_pkg::FUNC_GROW) ? S_DIV : S_EXEC;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    case (func_reg)
                        kvba_pkg::FUNC_GROW:
                        begin
                            slot_pres_reg[slot_reg] <= 1'b1;
                            if (quot_reg > kvba_pkg::DIVD_W'(have))
                            begin
                                if (quot_reg > kvba_pkg::DIVD_W'(kvba_pkg::MAX_BPS)
                                    || kvba_pkg::FC_W'(add) > free_count_reg)
                                begin
                                    if (have == '0)
                                    begin
                                        slot_pres_reg[slot_reg] <= 1'b0;
                                    end
                                end
                                else
                                begin
                                    slot_cnt_reg[slot_reg] <= kvba_pkg::CNT_W'(quot_reg);
                                    left_reg  <= add;
                                    state_reg <= S_GROW;
                                end
                            end
                        end
                        kvba_pkg::FUNC_RELEASE:
                        begin
                            if (slot_pres_reg[slot_reg])
                            begin
                                slot_cnt_reg[slot_reg]  <= '0;
                                slot_pres_reg[slot_reg] <= 1'b0;
                                left_reg  <= have;
                                state_reg <= S_REL;
                            end
                        end
                        kvba_pkg::FUNC_TRANSLATE:
                        begin
                            if (slot_pres_reg[slot_reg]
                                && kvba_pkg::CNT_W'(lb_reg) < have)
                            begin
                                state_reg <= S_TWAIT;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_GROW:
                begin
                    if (left_reg != '0)
                    begin
                        left_reg       <= left_reg - kvba_pkg::CNT_W'(1);
                        free_count_reg <= free_count_reg - kvba_pkg::FC_W'(1);
                        pend_reg       <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_REL:
                begin
                    if (stk_we)
                    begin
                        free_count_reg <= free_count_reg + kvba_pkg::FC_W'(1);
                    end
                    if (left_reg != '0)
                    begin
                        left_reg <= left_reg - kvba_pkg::CNT_W'(1);
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_TWAIT:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= req.func;
            slot_reg   <= req.request_slot;
            lb_reg     <= req.lblock;
            status_reg <= kvba_pkg::ST_OK;
            phys_reg   <= '0;
        end
        if (div_rsp.done)
        begin
            quot_reg <= div_rsp.quotient;
        end
        if (state_reg == S_EXEC)
        begin
            pos_reg <= (func_reg == kvba_pkg::FUNC_GROW) ? have[kvba_pkg::LB_W-1:0] : '0;
            case (func_reg)
                kvba_pkg::FUNC_GROW:
                begin
                    if (quot_reg > kvba_pkg::DIVD_W'(have))
                    begin
                        if (quot_reg > kvba_pkg::DIVD_W'(kvba_pkg::MAX_BPS))
                        begin
                            status_reg <= kvba_pkg::ST_LIMIT;
                        end
                        else if (kvba_pkg::FC_W'(add) > free_count_reg)
                        begin
                            status_reg <= kvba_pkg::ST_EXHAUSTED;
                        end
                    end
                end
                kvba_pkg::FUNC_RELEASE:
                begin
                    if (!slot_pres_reg[slot_reg])
                    begin
                        status_reg <= kvba_pkg::ST_UNKNOWN;
                    end
                end
                kvba_pkg::FUNC_TRANSLATE:
                begin
                    if (!slot_pres_reg[slot_reg])
                    begin
                        status_reg <= kvba_pkg::ST_UNKNOWN;
                    end
                    else if (kvba_pkg::CNT_W'(lb_reg) >= have)
                    begin
                        status_reg <= kvba_pkg::ST_RANGE;
                    end
                end
                default:
                begin
                    status_reg <= kvba_pkg::ST_OK;
                end
            endcase
        end
        else if ((state_reg == S_GROW || state_reg == S_REL) && left_reg != '0)
        begin
            pos_reg <= pos_reg + kvba_pkg::LB_W'(1);
        end
        if (state_reg == S_GROW && left_reg != '0)
        begin
            wa_reg <= {slot_reg, pos_reg};
        end
        if (state_reg == S_TWAIT)
        begin
            phys_reg <= tbl_rdata;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_phys_reg   <= phys_reg;
            out_pres_reg   <= slot_pres_reg[slot_reg];
            out_cnt_reg    <= slot_cnt_reg[slot_reg];
            out_free_reg   <= free_count_reg;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.status              = out_status_reg;
    assign rsp.physical_block      = out_phys_reg;
    assign rsp.present             = out_pres_reg;
    assign rsp.request_block_count = out_cnt_reg;
    assign rsp.free_block_count    = out_free_reg;

`include "kv_cache_block_allocator_macros.svh"

    `KVBA_ASSERT_ALWAYS(a_free_bound, free_count_reg <= kvba_pkg::FC_W'(kvba_pkg::POOL_DEPTH))
    `KVBA_ASSERT_IMPLY(a_grow_has_free, state_reg == S_GROW && left_reg != '0, free_count_reg != '0)
    `KVBA_ASSERT_IMPLY(a_no_accept_busy, state_reg != S_IDLE, !req.ready)

endmodule
